// File: sv/uet_pkg.sv
// Package for the ultrasonic echo timer: phase encoding, field widths,
// configuration and result structs, and the echo-window arithmetic.
// No dependencies.
package uet_pkg;

  // Largest distance the block is built for, in centimeters.
  localparam int unsigned MAX_DISTANCE_CM = 500;

  localparam int unsigned DIST_CFG_W = 9;
  localparam int unsigned RT_W       = 7;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned ECHO_US_W  = 16;
  localparam int unsigned OUTCOME_W  = 2;
  localparam int unsigned TCNT_W     = 4;
  localparam int unsigned CNT_W      = 17;

  localparam int unsigned DIST_MAX_W = $clog2(MAX_DISTANCE_CM + 1);
  localparam int unsigned DIST_W     = (DIST_MAX_W > DIST_CFG_W) ? DIST_MAX_W : DIST_CFG_W;
  localparam int unsigned ECHO_W     =
    $clog2(MAX_DISTANCE_CM * ((1 << RT_W) - 1) + ((1 << RT_W) - 1) / 2 + 1);
  localparam int unsigned SUM_BASE_W = (ECHO_W > TMO_W) ? ECHO_W : TMO_W;
  localparam int unsigned SUM_W      = ((SUM_BASE_W > CNT_W) ? SUM_BASE_W : CNT_W) + 1;

  localparam logic [TCNT_W-1:0] LOW_TICKS   = TCNT_W'(4);
  localparam logic [TCNT_W-1:0] HIGH_TICKS  = TCNT_W'(10);
  localparam logic [CNT_W-1:0]  ECHO_OFFSET = CNT_W'(13);
  localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_LIMIT  = DIST_W'(MAX_DISTANCE_CM);

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_DISTANCE = 2'd0;
  localparam logic [1:0] REG_ROUNDTRIP    = 2'd1;
  localparam logic [1:0] REG_START_TMO    = 2'd2;

  // Report outcome codes.
  localparam logic [OUTCOME_W-1:0] OUT_MEASURED  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_TIMEOUT   = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_NO_START  = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_TRIG_LOW   = 6'b000010,
    PH_TRIG_HIGH  = 6'b000100,
    PH_WAIT_CLEAR = 6'b001000,
    PH_WAIT_RISE  = 6'b010000,
    PH_MEASURE    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [DIST_CFG_W-1:0] max_distance_cm;
    logic [RT_W-1:0]       roundtrip_us_per_cm;
    logic [TMO_W-1:0]      start_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic                  trigger_enable;
    logic                  trigger_level;
    logic                  busy_res;
    logic                  report_valid;
    logic [ECHO_US_W-1:0]  echo_us;
    logic [OUTCOME_W-1:0]  outcome;
  } res_t;

  // Longest echo pulse accepted, from the clamped distance and round-trip rate.
  function automatic logic [SUM_W-1:0] max_echo_time(input cfg_t cfg);
    logic [DIST_W-1:0] d;
    logic [ECHO_W-1:0] prod;
    d = DIST_W'(cfg.max_distance_cm);
    if (d > DIST_LIMIT) begin
      d = DIST_LIMIT;
    end
    prod = ECHO_W'(d) * ECHO_W'(cfg.roundtrip_us_per_cm)
           + ECHO_W'(cfg.roundtrip_us_per_cm >> 1);
    return SUM_W'(prod);
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(CNT_MAX)) ? CNT_MAX : v[CNT_W-1:0];
  endfunction

endpackage

// File: sv/ultrasonic_echo_timer_top.sv
// Top level of the ultrasonic echo timer: stream ports, configuration
// registers and the result register around uet_core. Depends on uet_pkg.
//
//  Channel   Direction  Handshake         Contents
//  s_*       in         tvalid/tready     one tick sample: start request, echo level
//  m_*       out        tvalid/tready     one result word per tick sample
//  cfg_*     in         valid/ready       register index and write data
//
// Each sample word produces exactly one result word, in the cycle after it is
// taken; a sample can be taken every cycle while the sink keeps taking results.
// The sequencer and the echo-window multiply-add sit between the sample
// handshake and the result register. While a result waits, a new sample is
// still taken if the sink takes the waiting one in the same cycle. Reset returns
// the sequencer to idle and the configuration registers to their defaults.
module ultrasonic_echo_timer_top import uet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] start_req, [1] echo_level, [7:2] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] trigger_enable, [1] trigger_level,
                                 // [2] busy_res, [3] report_valid,
                                 // [19:4] echo_us, [23:20] zero
  output logic [1:0]  m_tuser,   // [1:0] outcome
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t res_reg;
  logic accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_distance_cm     <= DIST_CFG_W'(500);
      cfg.roundtrip_us_per_cm <= RT_W'(57);
      cfg.start_timeout_us    <= TMO_W'(5800);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_DISTANCE: cfg.max_distance_cm     <= cfg_data[DIST_CFG_W-1:0];
        REG_ROUNDTRIP:    cfg.roundtrip_us_per_cm <= cfg_data[RT_W-1:0];
        REG_START_TMO:    cfg.start_timeout_us    <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  uet_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .start_req  (s_tdata[0]),
    .echo_level (s_tdata[1]),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_reg <= res;
    end
  end

  assign m_tdata = {4'b0000, res_reg.echo_us, res_reg.report_valid, res_reg.busy_res,
                    res_reg.trigger_level, res_reg.trigger_enable};
  assign m_tuser = res_reg.outcome;

endmodule

// File: sv/uet_core.sv
// Ping sequencer for the ultrasonic echo timer: trigger pulse, echo wait
// and pulse timing, one tick per step. Depends on uet_pkg.
module uet_core import uet_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic start_req,
  input  logic echo_level,
  input  cfg_t cfg,
  output res_t res
);

  phase_t            phase, phase_next;
  logic [TCNT_W-1:0] trigger_count, trigger_count_next;
  logic [CNT_W-1:0]  elapsed_us, elapsed_us_next;
  logic [CNT_W-1:0]  limit_us, limit_us_next;

  logic [TCNT_W-1:0] tcnt_inc;
  logic [CNT_W-1:0]  el_inc;
  logic [CNT_W-1:0]  el_sub;
  logic [SUM_W-1:0]  echo_time;
  logic [SUM_W-1:0]  start_limit;

  assign tcnt_inc    = trigger_count + TCNT_W'(1);
  assign el_inc      = (elapsed_us != CNT_MAX) ? elapsed_us + CNT_W'(1) : elapsed_us;
  assign el_sub      = (el_inc > ECHO_OFFSET) ? el_inc - ECHO_OFFSET : '0;
  assign echo_time   = max_echo_time(cfg);
  assign start_limit = echo_time + SUM_W'(cfg.start_timeout_us);

  always_comb begin
    phase_next         = phase;
    trigger_count_next = trigger_count;
    elapsed_us_next    = elapsed_us;
    limit_us_next      = limit_us;
    res                = '0;
    case (phase)
      PH_TRIG_LOW: begin
        res.trigger_enable = 1'b1;
        trigger_count_next = tcnt_inc;
        if (tcnt_inc >= LOW_TICKS) begin
          phase_next         = PH_TRIG_HIGH;
          trigger_count_next = '0;
        end
      end
      PH_TRIG_HIGH: begin
        res.trigger_enable = 1'b1;
        res.trigger_level  = 1'b1;
        trigger_count_next = tcnt_inc;
        if (tcnt_inc >= HIGH_TICKS) begin
          phase_next         = PH_WAIT_CLEAR;
          trigger_count_next = '0;
          elapsed_us_next    = '0;
          limit_us_next      = sat_cnt(start_limit);
        end
      end
      PH_WAIT_CLEAR: begin
        elapsed_us_next = el_inc;
        if (!echo_level) begin
          phase_next = PH_WAIT_RISE;
        end else if (el_inc > limit_us) begin
          // The line never cleared: treat the high level as the rise.
          phase_next      = PH_MEASURE;
          elapsed_us_next = '0;
          limit_us_next   = sat_cnt(echo_time);
        end
      end
      PH_WAIT_RISE: begin
        elapsed_us_next = el_inc;
        if (echo_level) begin
          phase_next      = PH_MEASURE;
          elapsed_us_next = '0;
          limit_us_next   = sat_cnt(echo_time);
        end else if (el_inc > limit_us) begin
          phase_next       = PH_IDLE;
          res.report_valid = 1'b1;
          res.outcome      = OUT_NO_START;
        end
      end
      PH_MEASURE: begin
        elapsed_us_next = el_inc;
        if (!echo_level) begin
          phase_next       = PH_IDLE;
          res.report_valid = 1'b1;
          res.outcome      = OUT_MEASURED;
          res.echo_us      = (el_sub > CNT_W'({ECHO_US_W{1'b1}})) ? {ECHO_US_W{1'b1}}
                                                                : el_sub[ECHO_US_W-1:0];
        end else if (el_inc >= limit_us) begin
          phase_next       = PH_IDLE;
          res.report_valid = 1'b1;
          res.outcome      = OUT_TIMEOUT;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          res.trigger_enable = 1'b1;
          phase_next         = PH_TRIG_LOW;
          trigger_count_next = TCNT_W'(1);
        end
      end
    endcase
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      trigger_count <= '0;
      elapsed_us    <= '0;
      limit_us      <= '0;
    end else if (step) begin
      phase         <= phase_next;
      trigger_count <= trigger_count_next;
      elapsed_us    <= elapsed_us_next;
      limit_us      <= limit_us_next;
    end
  end

endmodule

// File: tb/ultrasonic_echo_timer_top_tb.sv
// Testbench for the ultrasonic echo timer top level: drives tick samples and
// register writes, predicts every result word and checks it field by field.
// Depends on uet_pkg and ultrasonic_echo_timer_top.
module ultrasonic_echo_timer_top_tb import uet_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_TICKS = 200;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_BURSTY} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ultrasonic_echo_timer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the registers and of the ping sequencer.
  logic [DIST_CFG_W-1:0] reg_dist = 9'd500;
  logic [RT_W-1:0]       reg_rt   = 7'd57;
  logic [TMO_W-1:0]      reg_tmo  = 16'd5800;
  phase_t                ping_phase = PH_IDLE;
  logic [TCNT_W-1:0]     trig_count = '0;
  logic [CNT_W-1:0]      ping_elapsed = '0;
  logic [CNT_W-1:0]      ping_limit = '0;

  res_t        echo_due[$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned echo_window_us();
    int unsigned d;
    d = (reg_dist > MAX_DISTANCE_CM) ? MAX_DISTANCE_CM : reg_dist;
    return d * reg_rt + (reg_rt >> 1);
  endfunction

  function automatic logic [CNT_W-1:0] clamp17(int unsigned v);
    return (v > CNT_MAX) ? CNT_MAX : v[CNT_W-1:0];
  endfunction

  function automatic void bump_elapsed();
    if (ping_elapsed != CNT_MAX) ping_elapsed = ping_elapsed + 1'b1;
  endfunction

  function automatic void open_pulse_window();
    ping_phase = PH_MEASURE;
    ping_elapsed = '0;
    ping_limit = clamp17(echo_window_us());
  endfunction

  // One tick of the sequencer: advances the mirror and returns the result word.
  function automatic res_t ping_step(bit start, bit echo);
    res_t r;
    int unsigned v;
    r = '0;
    case (ping_phase)
      PH_TRIG_LOW: begin
        r.trigger_enable = 1'b1;
        trig_count = trig_count + 1'b1;
        if (trig_count >= LOW_TICKS) begin
          ping_phase = PH_TRIG_HIGH;
          trig_count = '0;
        end
      end
      PH_TRIG_HIGH: begin
        r.trigger_enable = 1'b1;
        r.trigger_level = 1'b1;
        trig_count = trig_count + 1'b1;
        if (trig_count >= HIGH_TICKS) begin
          ping_phase = PH_WAIT_CLEAR;
          trig_count = '0;
          ping_elapsed = '0;
          ping_limit = clamp17(echo_window_us() + reg_tmo);
        end
      end
      PH_WAIT_CLEAR: begin
        bump_elapsed();
        if (!echo) ping_phase = PH_WAIT_RISE;
        else if (ping_elapsed > ping_limit) open_pulse_window();
      end
      PH_WAIT_RISE: begin
        bump_elapsed();
        if (echo) begin
          open_pulse_window();
        end else if (ping_elapsed > ping_limit) begin
          ping_phase = PH_IDLE;
          r.report_valid = 1'b1;
          r.outcome = OUT_NO_START;
        end
      end
      PH_MEASURE: begin
        bump_elapsed();
        if (!echo) begin
          v = (ping_elapsed > ECHO_OFFSET) ? ping_elapsed - ECHO_OFFSET : 0;
          r.echo_us = (v > 65535) ? 16'hFFFF : v[15:0];
          ping_phase = PH_IDLE;
          r.report_valid = 1'b1;
          r.outcome = OUT_MEASURED;
        end else if (ping_elapsed >= ping_limit) begin
          ping_phase = PH_IDLE;
          r.report_valid = 1'b1;
          r.outcome = OUT_TIMEOUT;
        end
      end
      default: begin
        ping_phase = PH_IDLE;
        if (start) begin
          r.trigger_enable = 1'b1;
          ping_phase = PH_TRIG_LOW;
          trig_count = 4'd1;
        end
      end
    endcase
    r.busy_res = (ping_phase != PH_IDLE);
    return r;
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < 40) $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Sends one tick word; the sender runs in bursts with random gaps between them.
  task automatic send_tick(bit start, bit echo);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = chance(25) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, echo, start};
    do @(posedge clk); while (!s_tready);
    echo_due.push_back(ping_step(start, echo));
    ticks_sent++;
  endtask

  task automatic wait_drained();
    while (echo_due.size() != 0) @(posedge clk);
  endtask

  // Registers are written only with no result word outstanding.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_DISTANCE: reg_dist = data[DIST_CFG_W-1:0];
      REG_ROUNDTRIP:    reg_rt = data[RT_W-1:0];
      REG_START_TMO:    reg_tmo = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int unsigned dist_cm, int unsigned rt, int unsigned tmo);
    write_reg(REG_MAX_DISTANCE, 16'(dist_cm));
    write_reg(REG_ROUNDTRIP, 16'(rt));
    write_reg(REG_START_TMO, 16'(tmo));
  endtask

  // A well-formed ping: start, trigger, echo high, low, the pulse, then the fall.
  task automatic run_ping(int unsigned clear_ticks, int unsigned rise_wait,
                          int unsigned pulse_len, int unsigned start_pct);
    send_tick(1'b1, 1'($urandom));
    repeat (LOW_TICKS + HIGH_TICKS - 1) send_tick(chance(start_pct), 1'($urandom));
    repeat (clear_ticks) send_tick(chance(start_pct), 1'b1);
    repeat (rise_wait) send_tick(chance(start_pct), 1'b0);
    repeat (pulse_len) send_tick(chance(start_pct), 1'b1);
    send_tick(1'b0, 1'b0);
    while (ping_phase != PH_IDLE) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_default_registers();
    run_ping(3, 20, 60, 0);
  endtask

  task automatic test_start_while_busy();
    run_ping(1, 2, 5, 100);
    run_ping(0, 4, 30, 50);
  endtask

  task automatic test_short_pulses();
    set_regs(1, 20, 10);
    run_ping(0, 2, 1, 0);
    run_ping(0, 2, 12, 0);
    run_ping(0, 2, 13, 0);
    run_ping(0, 2, 14, 0);
    run_ping(0, 2, 15, 0);
  endtask

  // Echo high through the whole start window is taken as the rise.
  task automatic test_echo_stuck_high();
    set_regs(0, 1, 0);
    run_ping(3, 0, 0, 0);
    set_regs(1, 4, 2);
    run_ping(12, 0, 0, 0);
  endtask

  // The fall on the tick the echo limit is reached is measured, not timed out.
  task automatic test_fall_at_limit();
    set_regs(2, 9, 5);
    run_ping(0, 2, 21, 0);
    run_ping(0, 2, 22, 0);
    run_ping(0, 2, 23, 0);
  endtask

  task automatic test_missing_echo();
    set_regs(1, 3, 3);
    run_ping(0, 0, 0, 0);
    run_ping(2, 0, 0, 0);
    run_ping(0, 6, 2, 0);
    run_ping(0, 7, 2, 0);
    run_ping(0, 8, 2, 0);
  endtask

  // The start deadline uses the registers at trigger release, the echo limit
  // those at the rise.
  task automatic test_register_sampling();
    set_regs(2, 4, 5);
    send_tick(1'b1, 1'b0);
    repeat (6) send_tick(1'b0, 1'($urandom));
    write_reg(REG_ROUNDTRIP, 16'd6);
    write_reg(REG_START_TMO, 16'd2);
    repeat (7) send_tick(1'b0, 1'($urandom));
    repeat (2) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    write_reg(REG_MAX_DISTANCE, 16'd1);
    while (ping_phase != PH_IDLE) send_tick(1'b0, 1'b1);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_UNUSED, 16'hFFFF);
    set_regs(0, 0, 0);
    run_ping(0, 0, 0, 0);
    run_ping(4, 0, 0, 0);
    run_ping(0, 0, 1, 0);
    set_regs(511, 127, 65535);
    run_ping(0, 3, 40, 0);
    // Distance above the built maximum is clamped, so this pulse times out.
    set_regs(511, 1, 0);
    run_ping(0, 3, 505, 0);
  endtask

  task automatic test_random_pings();
    int unsigned first, pings, win, deadline;
    logic [DIST_CFG_W-1:0] dist_sel;
    logic [RT_W-1:0] rt;
    first = ticks_sent;
    pings = 0;
    while (ticks_sent - first < RANDOM_TICKS) begin
      if (pings % 3 == 0) begin
        if (chance(10)) begin
          dist_sel = 9'($urandom);
          rt = 7'($urandom_range(0, 1));
        end else begin
          dist_sel = 9'($urandom_range(0, 6));
          rt = 7'($urandom_range(0, 15));
        end
        // Upper data bits beyond each register's width are ignored.
        write_reg(REG_MAX_DISTANCE, {7'($urandom), dist_sel});
        write_reg(REG_ROUNDTRIP, {9'($urandom), rt});
        write_reg(REG_START_TMO, 16'($urandom_range(0, 40)));
      end
      if (pings == 2) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      win = echo_window_us();
      deadline = win + reg_tmo;
      if (chance(15)) begin
        repeat ($urandom_range(8, 40)) send_tick(1'($urandom), 1'($urandom));
        while (ping_phase != PH_IDLE) send_tick(1'b0, 1'($urandom));
      end else begin
        run_ping(chance(70) ? $urandom_range(0, 3) : $urandom_range(0, deadline + 2),
                 chance(80) ? $urandom_range(0, deadline / 2) : $urandom_range(0, deadline + 3),
                 chance(80) ? $urandom_range(1, win + 1) : $urandom_range(0, win + 3),
                 10);
      end
      pings++;
    end
  endtask

  // Result checker.
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (echo_due.size() == 0) begin
        report_mismatch("unexpected result word", m_tdata, 0);
      end else begin
        want = echo_due.pop_front();
        if (m_tdata[0] !== want.trigger_enable)
          report_mismatch("trigger_enable", m_tdata[0], want.trigger_enable);
        if (m_tdata[1] !== want.trigger_level)
          report_mismatch("trigger_level", m_tdata[1], want.trigger_level);
        if (m_tdata[2] !== want.busy_res)
          report_mismatch("busy_res", m_tdata[2], want.busy_res);
        if (m_tdata[3] !== want.report_valid)
          report_mismatch("report_valid", m_tdata[3], want.report_valid);
        if (m_tdata[19:4] !== want.echo_us)
          report_mismatch("echo_us", m_tdata[19:4], want.echo_us);
        if (m_tuser !== want.outcome)
          report_mismatch("outcome", m_tuser, want.outcome);
      end
    end
  end

  // Receiver back-pressure: open, sparse and bursty stretches.
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_stall = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 3))
        0, 1:    rx_mode = RX_OPEN;
        2:       rx_mode = RX_SPARSE;
        default: rx_mode = RX_BURSTY;
      endcase
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_SPARSE: m_tready <= chance(80);
      default: begin
        if (rx_stall != 0) begin
          rx_stall--;
          m_tready <= 1'b0;
        end else if (chance(3)) begin
          rx_stall = $urandom_range(1, 12);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ultrasonic_echo_timer_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_registers();
    test_start_while_busy();
    test_short_pulses();
    test_echo_stuck_high();
    test_fall_at_limit();
    test_missing_echo();
    test_register_sampling();
    test_register_extremes();
    test_random_pings();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("ultrasonic_echo_timer_top_tb: PASS");
    end else begin
      $display("ultrasonic_echo_timer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
